>>> hdl/tbah_pkg.sv
`timescale 1ns / 1ps
package tbah_pkg;
	localparam int NB_POINTS = 32;
	localparam int ADDR_W = (NB_POINTS > 1) ? $clog2(NB_POINTS) : 1;
	localparam int CNT_W = ADDR_W + 1;
	localparam logic [31:0] NB_POINTS_W = 32'(NB_POINTS);
	localparam logic [31:0] LAST_SLOT_W = 32'(NB_POINTS - 1);

	localparam logic [15:0] RESET_UNDEF = 16'hFFFF;
	localparam logic [7:0] RESET_BIN_SECONDS = 8'd30;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_SECONDS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_UNDEF_CODE = CFG_IDX_W'(1);

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef struct packed {
		logic is_read;
		logic [31:0] elapsed;
		logic [15:0] value;
		logic [4:0] rslot;
	} tbah_cmd_t;
endpackage

>>> hdl/tbah_if.sv
`timescale 1ns / 1ps
interface tbah_in_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [31:0] timestamp;
	logic [15:0] sample_value;
	logic [4:0] read_slot;

	modport source(output valid, req_type, timestamp, sample_value, read_slot, input ready);
	modport sink(input valid, req_type, timestamp, sample_value, read_slot, output ready);
endinterface

interface tbah_out_if;
	logic valid;
	logic ready;
	logic [4:0] slot_index;
	logic [15:0] slot_value;
	logic slot_empty;

	modport source(output valid, slot_index, slot_value, slot_empty, input ready);
	modport sink(input valid, slot_index, slot_value, slot_empty, output ready);
endinterface

>>> hdl/time_binned_average_history_core.sv
// A read request goes from the queue through the idle, read-wait and done states before its word is raised.
// A sample runs two 32-step serial divides (bin number and bin average),
// plus a shift of the whole history when the history has to move.
// The back end handles one request at a time; a two-entry queue takes new requests meanwhile.
// Reset clears all control state; every history slot then reads as 65535.
`timescale 1ns / 1ps
module time_binned_average_history_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [tbah_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tbah_pkg::CFG_DATA_W-1:0] cfg_data,
	tbah_in_if.sink req,
	tbah_out_if.source rsp
);
	import tbah_pkg::*;

	logic [7:0] bin_seconds_q;
	logic [15:0] undef_code_q;
	logic cmd_valid;
	tbah_cmd_t cmd;
	logic cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_seconds_q <= RESET_BIN_SECONDS;
			undef_code_q <= RESET_UNDEF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BIN_SECONDS: begin
					bin_seconds_q <= cfg_data[7:0];
				end
				REG_UNDEF_CODE: begin
					undef_code_q <= cfg_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	tbah_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop)
	);

	tbah_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop),
		.bin_seconds(bin_seconds_q),
		.undef_code(undef_code_q),
		.rsp(rsp)
	);
endmodule

>>> hdl/tbah_ram.sv
`timescale 1ns / 1ps
module tbah_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

>>> hdl/tbah_div.sv
`timescale 1ns / 1ps
module tbah_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] dividend,
	input logic [15:0] divisor,
	output logic busy,
	output logic done,
	output logic [31:0] quotient
);
	import tbah_pkg::*;

	localparam logic [4:0] LAST_STEP = 5'd31;

	logic busy_q;
	logic done_q;
	logic [4:0] cnt_q;
	logic [31:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] dvs_q;
	logic [16:0] shifted;
	logic [16:0] trial;

	assign shifted = {rem_q, quo_q[31]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[16]) begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[15:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;
endmodule

>>> hdl/tbah_front.sv
`timescale 1ns / 1ps
module tbah_front (
	input logic clk,
	input logic arst_n,
	tbah_in_if.sink req,
	output logic cmd_valid,
	output tbah_pkg::tbah_cmd_t cmd,
	input logic cmd_pop
);
	import tbah_pkg::*;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam logic [QPTR_W:0] QFULL = (QPTR_W + 1)'(QDEPTH);

	tbah_cmd_t entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] cnt_q;
	logic started_q;
	logic [31:0] start_q;
	logic accept;
	logic is_sample;
	logic [31:0] start_eff;
	tbah_cmd_t new_cmd;

	assign req.ready = (cnt_q != QFULL);
	assign accept = req.valid && req.ready;
	assign is_sample = (req.req_type == REQ_SAMPLE);
	assign start_eff = started_q ? start_q : req.timestamp;

	always_comb begin
		new_cmd.is_read = (req.req_type == REQ_READ);
		new_cmd.elapsed = (req.timestamp >= start_eff) ? (req.timestamp - start_eff) : 32'd0;
		new_cmd.value = req.sample_value;
		new_cmd.rslot = req.read_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
			started_q <= 1'b0;
			start_q <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
				if (is_sample && !started_q) begin
					started_q <= 1'b1;
					start_q <= req.timestamp;
				end
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (accept && !cmd_pop) begin
				cnt_q <= cnt_q + (QPTR_W + 1)'(1);
			end else if (!accept && cmd_pop) begin
				cnt_q <= cnt_q - (QPTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_q[wr_ptr_q] <= new_cmd;
		end
	end

	assign cmd_valid = (cnt_q != '0);
	assign cmd = entry_q[rd_ptr_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QFULL)
		else $error("Command queue count exceeds its depth.");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cnt_q != '0)
		else $error("Command popped from an empty queue.");
	a_start_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		$past(started_q) |-> $stable(start_q))
		else $error("Start time changed after the first sample.");
endmodule

>>> hdl/tbah_back.sv
`timescale 1ns / 1ps
module tbah_back (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input tbah_pkg::tbah_cmd_t cmd,
	output logic cmd_pop,
	input logic [7:0] bin_seconds,
	input logic [15:0] undef_code,
	tbah_out_if.source rsp
);
	import tbah_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD_WAIT = 4'd1;
	localparam logic [3:0] S_BIN_DIV = 4'd2;
	localparam logic [3:0] S_PLAN = 4'd3;
	localparam logic [3:0] S_SHIFT = 4'd4;
	localparam logic [3:0] S_ACC = 4'd5;
	localparam logic [3:0] S_AVG_GO = 4'd6;
	localparam logic [3:0] S_AVG_DIV = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	localparam logic [CNT_W-1:0] NB_CNT = CNT_W'(NB_POINTS);

	logic [3:0] state_q;
	logic [NB_POINTS-1:0] slot_vld_q;
	logic [31:0] prev_bin_q;
	logic [31:0] sum_q;
	logic [15:0] count_q;
	logic rsp_valid_q;
	logic [4:0] rsp_index_q;
	logic [15:0] rsp_value_q;
	logic rsp_empty_q;

	logic is_read_q;
	logic [15:0] sval_q;
	logic [31:0] bin_q;
	logic newer_q;
	logic in_range_q;
	logic [ADDR_W-1:0] slot_q;
	logic [4:0] idx_q;
	logic [15:0] val_q;
	logic [CNT_W-1:0] shift_q;
	logic [CNT_W-1:0] sh_cnt_q;
	logic src_ok_s1;
	logic src_vld_s1;

	logic div_start;
	logic div_busy;
	logic div_done;
	logic [31:0] div_dividend;
	logic [15:0] div_divisor;
	logic [31:0] div_quotient;
	logic [7:0] bin_len;

	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [15:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [15:0] ram_rdata;

	logic [CNT_W:0] src;
	logic src_ok;
	logic [31:0] base;
	logic [31:0] amt;
	logic out_free;
	logic fire;
	logic [31:0] acc_sum;
	logic [15:0] acc_cnt;
	logic [15:0] shift_data;

	assign bin_len = (bin_seconds == 8'd0) ? 8'd1 : bin_seconds;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign fire = (state_q == S_DONE) && out_free;
	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;

	assign src = {1'b0, sh_cnt_q} + {1'b0, shift_q};
	assign src_ok = (sh_cnt_q < NB_CNT) && (src < {1'b0, NB_CNT});
	assign base = (prev_bin_q > LAST_SLOT_W) ? prev_bin_q : LAST_SLOT_W;
	assign amt = bin_q - base;
	assign acc_sum = newer_q ? 32'd0 : sum_q;
	assign acc_cnt = newer_q ? 16'd0 : count_q;
	assign shift_data = src_ok_s1 ? (src_vld_s1 ? ram_rdata : RESET_UNDEF) : undef_code;

	assign div_start = (cmd_pop && !cmd.is_read) || (state_q == S_AVG_GO);
	assign div_dividend = (state_q == S_IDLE) ? cmd.elapsed : sum_q;
	assign div_divisor = (state_q == S_IDLE) ? {8'd0, bin_len} : count_q;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = val_q;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: begin
				ram_raddr = ADDR_W'(cmd.rslot);
			end
			S_SHIFT: begin
				ram_raddr = ADDR_W'(src);
				ram_we = (sh_cnt_q != '0);
				ram_waddr = ADDR_W'(sh_cnt_q - CNT_W'(1));
				ram_wdata = shift_data;
			end
			S_DONE: begin
				ram_we = fire && !is_read_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			slot_vld_q <= '0;
			prev_bin_q <= '0;
			sum_q <= '0;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= cmd.is_read ? S_RD_WAIT : S_BIN_DIV;
					end
				end
				S_RD_WAIT: begin
					state_q <= S_DONE;
				end
				S_BIN_DIV: begin
					if (div_done) begin
						state_q <= S_PLAN;
					end
				end
				S_PLAN: begin
					if (bin_q > prev_bin_q && bin_q >= NB_POINTS_W) begin
						state_q <= S_SHIFT;
					end else begin
						state_q <= S_ACC;
					end
				end
				S_SHIFT: begin
					if (sh_cnt_q != '0) begin
						slot_vld_q[ADDR_W'(sh_cnt_q - CNT_W'(1))] <= 1'b1;
					end
					if (sh_cnt_q == NB_CNT) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (acc_cnt != 16'hFFFF) begin
						sum_q <= acc_sum + {16'd0, sval_q};
						count_q <= acc_cnt + 16'd1;
					end else begin
						sum_q <= acc_sum;
						count_q <= acc_cnt;
					end
					state_q <= S_AVG_GO;
				end
				S_AVG_GO: begin
					state_q <= S_AVG_DIV;
				end
				S_AVG_DIV: begin
					if (div_done) begin
						prev_bin_q <= bin_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						if (!is_read_q) begin
							slot_vld_q[slot_q] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				is_read_q <= cmd.is_read;
				sval_q <= cmd.value;
				idx_q <= cmd.rslot;
				slot_q <= ADDR_W'(cmd.rslot);
				in_range_q <= (32'(cmd.rslot) < NB_POINTS_W);
			end
			S_RD_WAIT: begin
				val_q <= in_range_q ?
					(slot_vld_q[slot_q] ? ram_rdata : RESET_UNDEF) : undef_code;
			end
			S_BIN_DIV: begin
				bin_q <= div_quotient;
			end
			S_PLAN: begin
				newer_q <= (bin_q > prev_bin_q);
				shift_q <= (amt >= NB_POINTS_W) ? NB_CNT : CNT_W'(amt);
				sh_cnt_q <= '0;
			end
			S_SHIFT: begin
				src_ok_s1 <= src_ok;
				src_vld_s1 <= slot_vld_q[ADDR_W'(src)];
				sh_cnt_q <= sh_cnt_q + CNT_W'(1);
			end
			S_AVG_DIV: begin
				val_q <= div_quotient[15:0];
				slot_q <= (bin_q < NB_POINTS_W) ? ADDR_W'(bin_q) : ADDR_W'(LAST_SLOT_W);
				idx_q <= (bin_q < NB_POINTS_W) ? 5'(bin_q) : 5'(LAST_SLOT_W);
			end
			S_DONE: begin
				if (out_free) begin
					rsp_index_q <= idx_q;
					rsp_value_q <= val_q;
					rsp_empty_q <= (val_q == undef_code);
				end
			end
			default: begin
			end
		endcase
	end

	tbah_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.busy(div_busy),
		.done(div_done),
		.quotient(div_quotient)
	);

	tbah_ram #(
		.WIDTH(16),
		.DEPTH(NB_POINTS)
	) u_hist (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rsp.valid = rsp_valid_q;
	assign rsp.slot_index = rsp_index_q;
	assign rsp.slot_value = rsp_value_q;
	assign rsp.slot_empty = rsp_empty_q;

	a_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> sh_cnt_q <= NB_CNT)
		else $error("History shift counter ran past the last slot.");
	a_word_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("Result word raised outside the completion state.");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("Divider started while busy.");
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_AVG_GO |-> count_q != 16'd0)
		else $error("Average taken over an empty bin.");
endmodule
